// ----- hdl/digit_template_sad_match_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the digit template SAD matcher
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIGIT_TEMPLATE_SAD_MATCH_UNIT_ASSERT_SVH
`define DIGIT_TEMPLATE_SAD_MATCH_UNIT_ASSERT_SVH

// condition holds at every edge
`define DTSM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DTSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define DTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/dtsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsm_pkg
// Field widths, codes and shared types of the digit template SAD matcher.
// ----------------------------------------------------------------------------
package dtsm_pkg;

  localparam int DIGIT_W = 4;
  localparam int POS_W   = 11;
  localparam int PIX_W   = 8;
  localparam int SAD_W   = 19;
  localparam int THR_W   = 20;

  localparam logic [THR_W-1:0] THR_RESET = 20'd400000;

  localparam int RES_FIFO_DEPTH = 16;
  localparam int RES_PTR_W      = 4;
  localparam int RES_CNT_W      = 5;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_CAND = 1'b1
  } dtsm_mode_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [SAD_W-1:0]   sad;
  } dtsm_cand_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] best_digit;
    logic [SAD_W-1:0]   min_sad;
    logic               accepted;
  } dtsm_res_t;

endpackage

// ----- hdl/dtsm_if.sv -----
// ----------------------------------------------------------------------------
// dtsm_in_if / dtsm_out_if
// Valid/ready channels for pixel items and match results.
// ----------------------------------------------------------------------------
interface dtsm_in_if;
  import dtsm_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [DIGIT_W-1:0] template_digit;
  logic [POS_W-1:0]   position;
  logic [PIX_W-1:0]   pixel;
  logic               last;

  modport source (output valid, mode, template_digit, position, pixel, last, input ready);
  modport sink   (input valid, mode, template_digit, position, pixel, last, output ready);
endinterface

interface dtsm_out_if;
  import dtsm_pkg::*;

  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] best_digit;
  logic [SAD_W-1:0]   min_sad;
  logic               accepted;

  modport source (output valid, best_digit, min_sad, accepted, input ready);
  modport sink   (input valid, best_digit, min_sad, accepted, output ready);
endinterface

// ----- hdl/digit_template_sad_match_unit.sv -----
// ----------------------------------------------------------------------------
// digit_template_sad_match_unit
// SAD digit matcher: stores NUM_TEMPLATES templates, accumulates the absolute
// difference of a streamed candidate image against each, reports the best.
// ----------------------------------------------------------------------------
//  port    | dir | carries
//  --------+-----+-----------------------------------------------------------
//  in_ch   | in  | mode, template_digit, position, pixel, last
//  out_ch  | out | best_digit, min_sad, accepted (one per last candidate item)
//  cfg_*   | in  | match_threshold write
//
// One item per cycle while in_ch.ready is high. After the edge that takes the
// last pixel, the match passes through RAM read on that edge, then difference,
// sum update, minimum tree levels, result queue. Results wait in a 16-entry
// queue; in_ch.ready drops only when 16 results are queued or in flight.
// Reset clears sums and queue and loads threshold 400000; templates keep
// whatever they held and must be loaded before use.
`include "digit_template_sad_match_unit_assert.svh"

module digit_template_sad_match_unit #(
  parameter int NUM_TEMPLATES = 10,
  parameter int IMG_WIDTH     = 32,
  parameter int IMG_HEIGHT    = 48
) (
  input  logic                      clk,
  input  logic                      rst_n,
  dtsm_in_if.sink                   in_ch,
  dtsm_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [dtsm_pkg::THR_W-1:0] cfg_wdata
);
  import dtsm_pkg::*;

  localparam int IMG_PIXELS = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW         = $clog2(IMG_PIXELS);
  localparam int SUM_EXT_W  = SAD_W + 1;
  localparam int OCC_W      = RES_CNT_W + 1;

  logic [THR_W-1:0] thr_r;

  logic accept, pos_ok, cand_last;
  logic [AW-1:0] addr;

  logic             s1_add_r, s1_last_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic             s2_last_r;
  logic             fin_vld_r;

  logic [PIX_W-1:0] ram_rd [NUM_TEMPLATES];
  logic [PIX_W-1:0] diff   [NUM_TEMPLATES];
  logic [PIX_W-1:0] d_r    [NUM_TEMPLATES];
  logic [SAD_W-1:0] sums_r [NUM_TEMPLATES];
  logic [SAD_W-1:0] sum_nxt [NUM_TEMPLATES];
  logic [SAD_W-1:0] fin_r  [NUM_TEMPLATES];
  dtsm_cand_t       cand   [NUM_TEMPLATES];

  logic       root_vld;
  dtsm_cand_t root;

  dtsm_res_t            fifo_r [RES_FIFO_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_CNT_W-1:0] cnt_r, inflight_r;
  logic [OCC_W-1:0]     occ;
  logic                 push, pop;
  dtsm_res_t            push_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign occ         = OCC_W'(inflight_r) + OCC_W'(cnt_r);
  assign in_ch.ready = occ < OCC_W'(RES_FIFO_DEPTH);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos_ok      = 32'(in_ch.position) < 32'(IMG_PIXELS);
  assign addr        = AW'(in_ch.position);
  assign cand_last   = accept && (in_ch.mode == MODE_CAND) && in_ch.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_add_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_last_r <= 1'b0;
      fin_vld_r <= 1'b0;
    end else begin
      s1_add_r  <= accept && (in_ch.mode == MODE_CAND) && pos_ok;
      s1_last_r <= cand_last;
      s2_last_r <= s1_last_r;
      fin_vld_r <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= in_ch.pixel;
  end

  genvar t;
  generate
    for (t = 0; t < NUM_TEMPLATES; t++) begin : g_tpl
      logic [SUM_EXT_W-1:0] sum_ext;

      dtsm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (IMG_PIXELS)
      ) u_ram (
        .clk   (clk),
        .we    (accept && (in_ch.mode == MODE_LOAD) && pos_ok &&
                (in_ch.template_digit == DIGIT_W'(t))),
        .waddr (addr),
        .wdata (in_ch.pixel),
        .raddr (addr),
        .rdata (ram_rd[t])
      );

      assign diff[t] = (ram_rd[t] > s1_pix_r) ? (ram_rd[t] - s1_pix_r)
                                              : (s1_pix_r - ram_rd[t]);

      always_ff @(posedge clk) begin
        d_r[t] <= s1_add_r ? diff[t] : '0;
      end

      assign sum_ext    = SUM_EXT_W'(sums_r[t]) + SUM_EXT_W'(d_r[t]);
      assign sum_nxt[t] = sum_ext[SAD_W] ? '1 : sum_ext[SAD_W-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          sums_r[t] <= '0;
        end else if (s2_last_r) begin
          sums_r[t] <= '0;
        end else begin
          sums_r[t] <= sum_nxt[t];
        end
      end

      always_ff @(posedge clk) begin
        if (s2_last_r) begin
          fin_r[t] <= sum_nxt[t];
        end
      end

      assign cand[t] = '{digit: DIGIT_W'(t), sad: fin_r[t]};
    end
  endgenerate

  dtsm_min_tree #(
    .N (NUM_TEMPLATES)
  ) u_tree (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fin_vld_r),
    .in_cand   (cand),
    .out_valid (root_vld),
    .out_cand  (root)
  );

  assign push     = root_vld;
  assign pop      = out_ch.valid && out_ch.ready;
  assign push_res = '{best_digit: root.digit,
                      min_sad:    root.sad,
                      accepted:   THR_W'(root.sad) < thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
      inflight_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r      <= cnt_r + RES_CNT_W'(push) - RES_CNT_W'(pop);
      inflight_r <= inflight_r + RES_CNT_W'(cand_last) - RES_CNT_W'(push);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_res;
    end
  end

  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.best_digit = fifo_r[rd_ptr_r].best_digit;
  assign out_ch.min_sad    = fifo_r[rd_ptr_r].min_sad;
  assign out_ch.accepted   = fifo_r[rd_ptr_r].accepted;

  `DTSM_ASSERT_ALWAYS(a_credit_bound, occ <= OCC_W'(RES_FIFO_DEPTH), "result credit overrun")
  `DTSM_ASSERT_IMP(a_no_overflow, push, cnt_r != RES_CNT_W'(RES_FIFO_DEPTH), "result queue overflow")
  `DTSM_ASSERT_IMP(a_push_tracked, push, inflight_r != '0, "result pushed with none in flight")
  `DTSM_ASSERT_NEXT(a_sums_cleared, s2_last_r, sums_r[0] == '0, "sums not cleared after last")

endmodule

// ----- hdl/dtsm_ram.sv -----
// ----------------------------------------------------------------------------
// dtsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/dtsm_min_tree.sv -----
// ----------------------------------------------------------------------------
// dtsm_min_tree
// Registered pairwise minimum tree over the template sums; ties keep the
// lower digit.
// ----------------------------------------------------------------------------
module dtsm_min_tree #(
  parameter int N = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  dtsm_pkg::dtsm_cand_t in_cand [N],
  output logic                 out_valid,
  output dtsm_pkg::dtsm_cand_t out_cand
);
  import dtsm_pkg::*;

  localparam int L    = $clog2(N);
  localparam int NPAD = 1 << L;

  dtsm_cand_t lvl [L+1][NPAD];
  logic [L-1:0] vld_r;

  genvar l, j;
  generate
    for (j = 0; j < NPAD; j++) begin : g_leaf
      if (j < N) begin : g_real
        assign lvl[0][j] = in_cand[j];
      end else begin : g_pad
        assign lvl[0][j] = '{digit: DIGIT_W'(j), sad: '1};
      end
    end

    for (l = 0; l < L; l++) begin : g_lvl
      if (l == 0) begin : g_v0
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[0] <= 1'b0;
          end else begin
            vld_r[0] <= in_valid;
          end
        end
      end else begin : g_vn
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[l] <= 1'b0;
          end else begin
            vld_r[l] <= vld_r[l-1];
          end
        end
      end

      for (j = 0; j < NPAD; j++) begin : g_node
        if (j < (NPAD >> (l + 1))) begin : g_cmp
          always_ff @(posedge clk) begin
            if (lvl[l][2*j+1].sad < lvl[l][2*j].sad) begin
              lvl[l+1][j] <= lvl[l][2*j+1];
            end else begin
              lvl[l+1][j] <= lvl[l][2*j];
            end
          end
        end else begin : g_idle
          assign lvl[l+1][j] = '{digit: DIGIT_W'(j), sad: '1};
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[L-1];
  assign out_cand  = lvl[L][0];

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Digit template SAD matcher testbench
// Loads templates at a pool of positions, then streams candidate images whose
// pixels sit at loaded positions or out of range. A shadow matcher predicts
// each best digit, minimum sum and accept flag, and every result is checked in
// order. Both channels idle at random, the receiver holds off long enough to
// stall the input, and the threshold is moved between phases.
// ----------------------------------------------------------------------------
module testbench;
  import dtsm_pkg::*;

  localparam int NUM_T      = 10;
  localparam int IMG_W      = 32;
  localparam int IMG_H      = 48;
  localparam int IMG_PIXELS = IMG_W * IMG_H;
  localparam int POS_MAX    = (1 << POS_W) - 1;
  localparam int unsigned SAD_MAX = (1 << SAD_W) - 1;
  localparam int SETTLE_CYCLES = 4 + $clog2(NUM_T) + 6;
  localparam logic [THR_W-1:0] THR_TOP = 20'd524288;

  typedef struct {
    dtsm_mode_t         mode;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   pos;
    logic [PIX_W-1:0]   pix;
    logic               last;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [THR_W-1:0] cfg_wdata;

  dtsm_in_if  in_ch ();
  dtsm_out_if out_ch ();

  digit_template_sad_match_unit #(
    .NUM_TEMPLATES (NUM_T),
    .IMG_WIDTH     (IMG_W),
    .IMG_HEIGHT    (IMG_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow matcher state
  logic [PIX_W-1:0] tmpl_img [NUM_T][IMG_PIXELS];
  int unsigned      sad_acc [NUM_T] = '{default: 0};
  logic [THR_W-1:0] thr_shadow = THR_RESET;
  dtsm_res_t        pending_matches [$];

  pixel_item_t   pixel_q [$];
  logic [POS_W-1:0] loaded_pos [$];

  int fail_cnt     = 0;
  int items_taken  = 0;
  int loads_taken  = 0;
  int results_seen = 0;
  int thr_writes   = 0;
  int unsigned queued_items = 0;

  // driver / receiver pacing
  pixel_item_t cur_item;
  int  gap_left  = 0;
  int  drv_calm  = 0;
  int  gap_roll;
  int  stall_left = 0;
  int  rcv_calm  = 0;
  int  rdy_roll;
  logic burst_phase = 1'b0;
  logic burst_held  = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic void queue_pixel(input dtsm_mode_t m, input logic [DIGIT_W-1:0] dg,
                                      input logic [POS_W-1:0] ps, input logic [PIX_W-1:0] px,
                                      input logic lst);
    pixel_item_t it;
    it.mode  = m;
    it.digit = dg;
    it.pos   = ps;
    it.pix   = px;
    it.last  = lst;
    pixel_q.push_back(it);
    queued_items++;
  endfunction

  function automatic logic [POS_W-1:0] pick_loaded_pos();
    return loaded_pos[$urandom_range(0, loaded_pos.size() - 1)];
  endfunction

  // ---------------- prediction ----------------
  task automatic apply_pixel(input pixel_item_t it);
    int unsigned d;
    int unsigned s;
    int          best;
    int unsigned best_sum;
    dtsm_res_t   r;
    if (it.mode == MODE_LOAD) begin
      loads_taken++;
      if (it.digit < NUM_T && it.pos < IMG_PIXELS)
        tmpl_img[it.digit][it.pos] = it.pix;
    end else begin
      if (it.pos < IMG_PIXELS) begin
        for (int t = 0; t < NUM_T; t++) begin
          d = (tmpl_img[t][it.pos] > it.pix) ? tmpl_img[t][it.pos] - it.pix
                                              : it.pix - tmpl_img[t][it.pos];
          s = sad_acc[t] + d;
          sad_acc[t] = (s > SAD_MAX) ? SAD_MAX : s;
        end
      end
      if (it.last) begin
        best = 0;
        best_sum = sad_acc[0];
        for (int t = 1; t < NUM_T; t++) begin
          if (sad_acc[t] < best_sum) begin
            best_sum = sad_acc[t];
            best = t;
          end
        end
        r.best_digit = best[DIGIT_W-1:0];
        r.min_sad    = best_sum[SAD_W-1:0];
        r.accepted   = (best_sum < thr_shadow);
        pending_matches.push_back(r);
        for (int t = 0; t < NUM_T; t++) sad_acc[t] = 0;
      end
    end
  endtask

  task automatic check_match();
    dtsm_res_t want;
    if (pending_matches.size() == 0) begin
      $error("unexpected result: best_digit %0d min_sad %0d accepted %0d",
             out_ch.best_digit, out_ch.min_sad, out_ch.accepted);
      fail_cnt++;
    end else begin
      want = pending_matches.pop_front();
      results_seen++;
      if (out_ch.best_digit !== want.best_digit) begin
        $error("best_digit mismatch: expected %0d, actual %0d",
               want.best_digit, out_ch.best_digit);
        fail_cnt++;
      end
      if (out_ch.min_sad !== want.min_sad) begin
        $error("min_sad mismatch: expected %0d, actual %0d", want.min_sad, out_ch.min_sad);
        fail_cnt++;
      end
      if (out_ch.accepted !== want.accepted) begin
        $error("accepted mismatch: expected %0d, actual %0d", want.accepted, out_ch.accepted);
        fail_cnt++;
      end
    end
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_match();
      if (in_ch.valid && in_ch.ready) begin
        cur_item.mode  = dtsm_mode_t'(in_ch.mode);
        cur_item.digit = in_ch.template_digit;
        cur_item.pos   = in_ch.position;
        cur_item.pix   = in_ch.pixel;
        cur_item.last  = in_ch.last;
        apply_pixel(cur_item);
        items_taken++;
      end
    end
  end

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.mode           <= MODE_LOAD;
      in_ch.template_digit <= '0;
      in_ch.position       <= '0;
      in_ch.pixel          <= '0;
      in_ch.last           <= 1'b0;
      gap_left             <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (pixel_q.size() != 0) begin
        in_ch.mode           <= pixel_q[0].mode;
        in_ch.template_digit <= pixel_q[0].digit;
        in_ch.position       <= pixel_q[0].pos;
        in_ch.pixel          <= pixel_q[0].pix;
        in_ch.last           <= pixel_q[0].last;
        in_ch.valid          <= 1'b1;
        void'(pixel_q.pop_front());
        if (drv_calm > 0) begin
          drv_calm <= drv_calm - 1;
          gap_left <= 0;
        end else begin
          gap_roll = $urandom_range(0, 99);
          if (gap_roll < 2) begin
            drv_calm <= $urandom_range(20, 120);
            gap_left <= 0;
          end else if (gap_roll < 70) gap_left <= 0;
          else if (gap_roll < 95) gap_left <= $urandom_range(1, 3);
          else gap_left <= $urandom_range(8, 30);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
      burst_held   <= 1'b0;
    end else if (burst_phase && !burst_held) begin
      // long hold-off so queued results back up into the input
      burst_held   <= 1'b1;
      stall_left   <= 300;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rcv_calm > 0) begin
      rcv_calm     <= rcv_calm - 1;
      out_ch.ready <= 1'b1;
    end else begin
      rdy_roll = $urandom_range(0, 99);
      if (rdy_roll < 2) begin
        rcv_calm     <= $urandom_range(50, 150);
        out_ch.ready <= 1'b1;
      end else if (rdy_roll < 75) out_ch.ready <= 1'b1;
      else if (rdy_roll < 95) begin
        stall_left   <= $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        stall_left   <= $urandom_range(20, 60);
        out_ch.ready <= 1'b0;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_ch.valid || pending_matches.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_shadow = v;
    thr_writes++;
  endtask

  task automatic queue_image(input int unsigned len);
    logic [POS_W-1:0] ps;
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        queue_pixel(MODE_LOAD, DIGIT_W'($urandom_range(0, NUM_T - 1)), pick_loaded_pos(),
                    PIX_W'($urandom), 1'($urandom_range(0, 1)));
      ps = ($urandom_range(0, 19) == 0) ? POS_W'($urandom_range(IMG_PIXELS, POS_MAX))
                                        : pick_loaded_pos();
      queue_pixel(MODE_CAND, DIGIT_W'($urandom_range(0, 15)), ps, PIX_W'($urandom),
                  k == len - 1);
    end
  endtask

  task automatic run_random_phase(input int unsigned budget);
    int unsigned start;
    int          roll;
    int unsigned len;
    start = queued_items;
    while (queued_items - start < budget) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) len = $urandom_range(1, 8);
        else if (roll < 95) len = $urandom_range(9, 30);
        else len = $urandom_range(31, 80);
        queue_image(len);
      end else if (roll < 92) begin
        queue_pixel(MODE_LOAD, DIGIT_W'($urandom_range(0, 15)),
                    POS_W'($urandom_range(0, POS_MAX)), PIX_W'($urandom),
                    1'($urandom_range(0, 1)));
      end else begin
        // stray pixel without last: folds into the following image
        queue_pixel(MODE_CAND, DIGIT_W'($urandom_range(0, 15)), pick_loaded_pos(),
                    PIX_W'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    logic [PIX_W-1:0] val;
    logic [THR_W-1:0] phase_thr [5];
    int spin;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // template pool: position 0 all equal, 31 all zero, 1535 lowest at digits 4 and 8
    loaded_pos.push_back(0);
    loaded_pos.push_back(31);
    loaded_pos.push_back(POS_W'(IMG_PIXELS - 1));
    repeat (21) loaded_pos.push_back(POS_W'($urandom_range(32, IMG_PIXELS - 2)));
    foreach (loaded_pos[i]) begin
      for (int d = 0; d < NUM_T; d++) begin
        if (loaded_pos[i] == 0) val = 8'd128;
        else if (loaded_pos[i] == 31) val = 8'd0;
        else if (loaded_pos[i] == IMG_PIXELS - 1) val = (d == 4 || d == 8) ? 8'd0 : 8'd255;
        else val = PIX_W'($urandom);
        queue_pixel(MODE_LOAD, DIGIT_W'(d), loaded_pos[i], val, 1'($urandom_range(0, 1)));
      end
    end
    wait_idle();

    // directed
    queue_pixel(MODE_CAND, 0, 0, 128, 1'b1);                       // all sums tie at zero
    queue_pixel(MODE_CAND, 0, POS_W'(IMG_PIXELS - 1), 0, 1'b1);    // tie between digits 4 and 8
    queue_pixel(MODE_CAND, 9, 0, 255, 1'b0);
    queue_pixel(MODE_CAND, 9, 0, 0, 1'b1);
    queue_pixel(MODE_CAND, 0, POS_W'(POS_MAX), 255, 1'b1);         // out of range, still emits
    queue_pixel(MODE_CAND, 0, POS_W'(IMG_PIXELS), 9, 1'b0);
    queue_pixel(MODE_CAND, 0, POS_W'(IMG_PIXELS - 1), 255, 1'b1);
    queue_pixel(MODE_LOAD, 10, 0, 0, 1'b0);                        // digit out of range
    queue_pixel(MODE_LOAD, 15, POS_W'(IMG_PIXELS - 1), 255, 1'b1);
    queue_pixel(MODE_LOAD, 9, POS_W'(POS_MAX), 255, 1'b0);         // position out of range
    queue_pixel(MODE_LOAD, 0, POS_W'(IMG_PIXELS + 64), 17, 1'b1);
    queue_pixel(MODE_CAND, 15, 0, 128, 1'b1);
    set_threshold('0);
    queue_pixel(MODE_CAND, 0, POS_W'(IMG_PIXELS - 1), 0, 1'b1);    // zero sum not below zero
    set_threshold(THR_TOP);
    queue_pixel(MODE_CAND, 0, 0, 128, 1'b1);

    phase_thr[0] = 20'd1;
    phase_thr[1] = THR_W'($urandom_range(0, 4000));
    phase_thr[2] = THR_W'($urandom_range(0, 524288));
    phase_thr[3] = THR_W'($urandom_range(0, 4000));
    phase_thr[4] = THR_RESET;
    for (int ph = 0; ph < 5; ph++) begin
      set_threshold(phase_thr[ph]);
      run_random_phase(60);
      if (ph == 2) begin
        wait_idle();
        burst_phase <= 1'b1;
        repeat (60)
          queue_pixel(MODE_CAND, DIGIT_W'($urandom_range(0, 15)), pick_loaded_pos(),
                      PIX_W'($urandom), 1'b1);
        wait_idle();
        burst_phase <= 1'b0;
      end
    end

    spin = 0;
    while (spin < 20000 &&
           (pixel_q.size() != 0 || in_ch.valid || pending_matches.size() != 0)) begin
      @(negedge clk);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_matches.size() != 0) begin
      $error("%0d expected results never arrived", pending_matches.size());
      fail_cnt++;
    end

    $display("Run covered %0d pixel items (%0d template loads) and %0d match results,",
             items_taken, loads_taken, results_seen);
    $display("over %0d threshold settings including zero and the top of the range.",
             thr_writes);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- digit_template_sad_match_unit.f -----
+incdir+hdl
hdl/dtsm_pkg.sv
hdl/dtsm_if.sv
hdl/dtsm_ram.sv
hdl/dtsm_min_tree.sv
hdl/digit_template_sad_match_unit.sv
verif/testbench.sv
